### rtl/ppt_pkg.sv
`timescale 1ns / 1ps
package ppt_pkg;

    // operation codes
    localparam logic [1:0] FUNC_FILL  = 2'd0;
    localparam logic [1:0] FUNC_ADOPT = 2'd1;

    // shift-add multiplier sizes
    localparam int MUL_A_W = 56;
    localparam int MUL_B_W = 41;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // restoring divider sizes
    localparam int DIV_N_W = 72;
    localparam int DIV_D_W = 33;
    localparam int DIV_Q_W = 40;
    localparam int DIV_C_W = $clog2(DIV_N_W);

    localparam logic [63:0] MAX64   = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIN64   = 64'h8000_0000_0000_0000;
    localparam logic [23:0] MULT_RESET = 24'd256;

    typedef struct packed {
        logic [1:0]          func;
        logic                sell_side;
        logic [19:0]         fill_size;
        logic signed [39:0]  price;
        logic signed [31:0]  fill_fee;
        logic signed [31:0]  adopted_position;
        logic signed [39:0]  mark_price;
        logic                mark_valid;
    } ppt_in_t;

    typedef struct packed {
        logic signed [63:0]  realised_this_fill;
        logic signed [31:0]  net_position;
        logic signed [39:0]  average_price;
        logic signed [63:0]  realised_total;
        logic signed [63:0]  fees_total;
        logic signed [63:0]  unrealised_pnl;
        logic signed [63:0]  net_pnl;
        logic [47:0]         contracts_total;
    } ppt_out_t;

    // Q.24 product to Q.16 money, truncated toward zero, saturated
    function automatic logic [63:0] money(input logic neg, input logic [MUL_P_W-1:0] p);
        logic [MUL_P_W-9:0] s;
        logic [63:0]        lim;
        logic [63:0]        m;
        s   = p[MUL_P_W-1:8];
        lim = neg ? MIN64 : MAX64;
        if (s > (MUL_P_W-8)'(lim)) m = lim;
        else m = s[63:0];
        return neg ? (~m + 64'd1) : m;
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a + b;
        if ((a[63] == b[63]) && (r[63] != a[63])) r = a[63] ? MIN64 : MAX64;
        return r;
    endfunction

    function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a - b;
        if ((a[63] != b[63]) && (r[63] != a[63])) r = a[63] ? MIN64 : MAX64;
        return r;
    endfunction

endpackage

### rtl/position_pnl_tracker.sv
`timescale 1ns / 1ps
// Average-cost position and P&L tracker. Each item (fill, adopt or report) is
// processed alone: s_ready is high only while the block is idle, and one
// result item follows every input item on the m_ channel. The work runs on a
// shared shift-add multiplier (one multiplier bit per cycle, stopping early
// when the remaining bits are zero) and a restoring divider under a small
// sequencer. A report without a mark uses neither unit. The longest item is
// a fill that adds to a full-scale position followed by a marked unrealised
// figure: four multiplications and the division run one after the other.
// The next item is taken only once the result has been accepted on m_.
// cfg_we writes contract_multiplier (unsigned Q16.8); write it
// only while the block is idle.
module position_pnl_tracker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [23:0]         cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  ppt_pkg::ppt_in_t    s_item,
    output logic                m_valid,
    input  logic                m_ready,
    output ppt_pkg::ppt_out_t   m_item
);

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_DEC  = 12'b0000_0000_0010,  // decode, fees and count
        S_MA   = 12'b0000_0000_0100,  // |avg| * |pos|
        S_MB   = 12'b0000_0000_1000,  // |price| * size
        S_DV   = 12'b0000_0001_0000,  // re-average division
        S_MC   = 12'b0000_0010_0000,  // closing * multiplier
        S_MD   = 12'b0000_0100_0000,  // times |price - avg|
        S_POST = 12'b0000_1000_0000,
        S_UA   = 12'b0001_0000_0000,  // |pos| * multiplier
        S_UB   = 12'b0010_0000_0000,  // times |mark - avg|
        S_NET  = 12'b0100_0000_0000,
        S_OUT  = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    ppt_pkg::ppt_in_t   in_reg;
    ppt_pkg::ppt_out_t  out_reg;
    logic [23:0]        mult_reg;

    // accounting state
    logic signed [31:0] pos_reg;
    logic signed [39:0] avg_reg;
    logic [63:0]        realised_reg;
    logic [63:0]        fees_reg;
    logic [47:0]        contracts_reg;

    // per-item scratch
    logic [63:0]        rnow_reg;
    logic [63:0]        unreal_reg;
    logic [ppt_pkg::DIV_N_W-1:0] keep_reg;
    logic               sn_reg;

    // shared units
    logic                          mul_start;
    logic [ppt_pkg::MUL_A_W-1:0]   mul_a;
    logic [ppt_pkg::MUL_B_W-1:0]   mul_b;
    logic                          mul_done;
    logic [ppt_pkg::MUL_P_W-1:0]   mul_prod;
    logic                          div_start;
    logic [ppt_pkg::DIV_N_W-1:0]   div_num;
    logic                          div_done;
    logic [ppt_pkg::DIV_Q_W-1:0]   div_quot;

    // fill decode
    logic [19:0]        size;
    logic signed [32:0] q_s;
    logic signed [32:0] total_s;
    logic [32:0]        total_mag;
    logic               total_nz;
    logic               tot_pos;
    logic [31:0]        pos_mag;
    logic [31:0]        pos_sat;
    logic [39:0]        avg_mag;
    logic [39:0]        price_mag;
    logic [31:0]        closing;
    logic               same_dir;
    logic signed [40:0] diff_f;
    logic [40:0]        diff_f_mag;
    logic signed [40:0] diff_u;
    logic [40:0]        diff_u_mag;
    logic               neg_f;
    logic               neg_u;
    logic [48:0]        cnt_sum;

    // re-average numerator
    logic [ppt_pkg::DIV_N_W-1:0] b_term;
    logic               a_ge_b;
    logic               sa;
    logic               sb;

    assign size      = in_reg.fill_size;
    assign q_s       = in_reg.sell_side ? -$signed({13'd0, size}) : $signed({13'd0, size});
    assign total_s   = 33'(pos_reg) + q_s;
    assign total_mag = total_s[32] ? 33'(-total_s) : 33'(total_s);
    assign total_nz  = total_s != '0;
    assign tot_pos   = !total_s[32] && total_nz;
    assign pos_mag   = pos_reg[31] ? 32'(-pos_reg) : 32'(pos_reg);
    assign avg_mag   = avg_reg[39] ? 40'(-avg_reg) : 40'(avg_reg);
    assign price_mag = in_reg.price[39] ? 40'(-in_reg.price) : 40'(in_reg.price);
    assign closing   = ({12'd0, size} < pos_mag) ? {12'd0, size} : pos_mag;
    // from flat, or a fill that adds to the position
    assign same_dir  = (pos_reg == '0) ||
                       (!pos_reg[31] == (!in_reg.sell_side && (size != '0)));
    // clamp the position to 32 bits when a fill overflows it
    assign pos_sat   = (total_s[32] != total_s[31]) ?
                       (total_s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : total_s[31:0];

    assign diff_f     = 41'(in_reg.price) - 41'(avg_reg);
    assign diff_f_mag = diff_f[40] ? 41'(-diff_f) : 41'(diff_f);
    assign diff_u     = 41'(in_reg.mark_price) - 41'(avg_reg);
    assign diff_u_mag = diff_u[40] ? 41'(-diff_u) : 41'(diff_u);
    assign neg_f      = pos_reg[31] != diff_f[40];
    assign neg_u      = pos_reg[31] != diff_u[40];
    assign cnt_sum    = {1'b0, contracts_reg} + {29'd0, size};

    assign b_term = ppt_pkg::DIV_N_W'(mul_prod);
    assign a_ge_b = keep_reg >= b_term;
    assign sa     = avg_reg[39];
    assign sb     = in_reg.price[39];

    // signed combine of the two weighted terms
    always_comb begin
        if (sa == sb) div_num = keep_reg + b_term;
        else if (a_ge_b) div_num = keep_reg - b_term;
        else div_num = b_term - keep_reg;
    end

    ppt_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    ppt_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (total_mag),
        .done    (div_done),
        .quot    (div_quot)
    );

    // sequencer and operand selection
    always_comb begin
        state_next = state_reg;
        mul_start  = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_DEC;
            end
            S_DEC: begin
                if (in_reg.func == ppt_pkg::FUNC_FILL) begin
                    if (same_dir) begin
                        if (total_nz) begin
                            mul_start  = 1'b1;
                            mul_a      = ppt_pkg::MUL_A_W'(avg_mag);
                            mul_b      = ppt_pkg::MUL_B_W'(pos_mag);
                            state_next = S_MA;
                        end else begin
                            state_next = S_POST;
                        end
                    end else begin
                        mul_start  = 1'b1;
                        mul_a      = ppt_pkg::MUL_A_W'(mult_reg);
                        mul_b      = ppt_pkg::MUL_B_W'(closing);
                        state_next = S_MC;
                    end
                end else begin
                    state_next = S_POST;
                end
            end
            S_MA: begin
                if (mul_done) begin
                    mul_start  = 1'b1;
                    mul_a      = ppt_pkg::MUL_A_W'(price_mag);
                    mul_b      = ppt_pkg::MUL_B_W'(size);
                    state_next = S_MB;
                end
            end
            S_MB: begin
                if (mul_done) begin
                    div_start  = 1'b1;
                    state_next = S_DV;
                end
            end
            S_DV: begin
                if (div_done) state_next = S_POST;
            end
            S_MC: begin
                if (mul_done) begin
                    mul_start  = 1'b1;
                    mul_a      = mul_prod[ppt_pkg::MUL_A_W-1:0];
                    mul_b      = diff_f_mag;
                    state_next = S_MD;
                end
            end
            S_MD: begin
                if (mul_done) state_next = S_POST;
            end
            S_POST: begin
                if (in_reg.mark_valid && (pos_reg != '0)) begin
                    mul_start  = 1'b1;
                    mul_a      = ppt_pkg::MUL_A_W'(mult_reg);
                    mul_b      = ppt_pkg::MUL_B_W'(pos_mag);
                    state_next = S_UA;
                end else begin
                    state_next = S_NET;
                end
            end
            S_UA: begin
                if (mul_done) begin
                    mul_start  = 1'b1;
                    mul_a      = mul_prod[ppt_pkg::MUL_A_W-1:0];
                    mul_b      = diff_u_mag;
                    state_next = S_UB;
                end
            end
            S_UB: begin
                if (mul_done) state_next = S_NET;
            end
            S_NET: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (m_ready) state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mult_reg <= ppt_pkg::MULT_RESET;
        end else if (cfg_we) begin
            mult_reg <= cfg_wdata;
        end
    end

    // accounting state updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= '0;
            avg_reg       <= '0;
            realised_reg  <= '0;
            fees_reg      <= '0;
            contracts_reg <= '0;
        end else begin
            unique case (state_reg)
                S_DEC: begin
                    if (in_reg.func == ppt_pkg::FUNC_FILL) begin
                        fees_reg      <= ppt_pkg::sat_add(fees_reg, 64'(in_reg.fill_fee));
                        contracts_reg <= cnt_sum[48] ? '1 : cnt_sum[47:0];
                        // flat and no size: nothing to average
                        if (same_dir && !total_nz) begin
                            avg_reg <= '0;
                            pos_reg <= '0;
                        end
                    end else if (in_reg.func == ppt_pkg::FUNC_ADOPT) begin
                        pos_reg <= in_reg.adopted_position;
                        avg_reg <= (in_reg.adopted_position != '0) ? in_reg.price : '0;
                    end
                end
                S_DV: begin
                    if (div_done) begin
                        avg_reg <= sn_reg ? 40'(-div_quot) : div_quot;
                        pos_reg <= pos_sat;
                    end
                end
                S_MD: begin
                    if (mul_done) begin
                        realised_reg <= ppt_pkg::sat_add(realised_reg,
                                                         ppt_pkg::money(neg_f, mul_prod));
                        pos_reg <= total_s[31:0];
                        // landing flat clears, crossing zero opens at the fill price
                        if (!total_nz) avg_reg <= '0;
                        else if (tot_pos != !pos_reg[31]) avg_reg <= in_reg.price;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // item scratch and result
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) in_reg <= s_item;
            end
            S_DEC: begin
                rnow_reg   <= '0;
                unreal_reg <= '0;
            end
            S_MA: begin
                if (mul_done) keep_reg <= ppt_pkg::DIV_N_W'(mul_prod);
            end
            S_MB: begin
                if (mul_done) sn_reg <= (sa == sb) ? sa : (a_ge_b ? sa : sb);
            end
            S_MD: begin
                if (mul_done) rnow_reg <= ppt_pkg::money(neg_f, mul_prod);
            end
            S_UB: begin
                if (mul_done) unreal_reg <= ppt_pkg::money(neg_u, mul_prod);
            end
            S_NET: begin
                out_reg.realised_this_fill <= rnow_reg;
                out_reg.net_position       <= pos_reg;
                out_reg.average_price      <= avg_reg;
                out_reg.realised_total     <= realised_reg;
                out_reg.fees_total         <= fees_reg;
                out_reg.unrealised_pnl     <= unreal_reg;
                out_reg.net_pnl            <= ppt_pkg::sat_sub(
                                                  ppt_pkg::sat_add(realised_reg, unreal_reg),
                                                  fees_reg);
                out_reg.contracts_total    <= contracts_reg;
            end
            default: begin
            end
        endcase
    end

    assign s_ready = state_reg == S_IDLE;
    assign m_valid = state_reg == S_OUT;
    assign m_item  = out_reg;

endmodule

### rtl/ppt_mul.sv
`timescale 1ns / 1ps
module ppt_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ppt_pkg::MUL_A_W-1:0]   a,
    input  logic [ppt_pkg::MUL_B_W-1:0]   b,
    output logic                          done,
    output logic [ppt_pkg::MUL_P_W-1:0]   prod
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [ppt_pkg::MUL_P_W-1:0]   acc_reg;
    logic [ppt_pkg::MUL_P_W-1:0]   a_sh_reg;
    logic [ppt_pkg::MUL_B_W-1:0]   b_sh_reg;

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (b_sh_reg[ppt_pkg::MUL_B_W-1:1] == '0)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // one multiplier bit per cycle, stops once the rest is zero
    always_ff @(posedge aclk) begin
        if (start) begin
            acc_reg  <= '0;
            a_sh_reg <= ppt_pkg::MUL_P_W'(a);
            b_sh_reg <= b;
        end else if (busy_reg) begin
            if (b_sh_reg[0]) acc_reg <= acc_reg + a_sh_reg;
            a_sh_reg <= a_sh_reg << 1;
            b_sh_reg <= b_sh_reg >> 1;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

### rtl/ppt_div.sv
`timescale 1ns / 1ps
module ppt_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ppt_pkg::DIV_N_W-1:0]   num,
    input  logic [ppt_pkg::DIV_D_W-1:0]   den,
    output logic                          done,
    output logic [ppt_pkg::DIV_Q_W-1:0]   quot
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [ppt_pkg::DIV_C_W-1:0]   cnt_reg;
    logic [ppt_pkg::DIV_N_W-1:0]   num_reg;
    logic [ppt_pkg::DIV_D_W-1:0]   den_reg;
    logic [ppt_pkg::DIV_D_W-1:0]   rem_reg;
    logic [ppt_pkg::DIV_Q_W-1:0]   q_reg;
    logic [ppt_pkg::DIV_D_W:0]     rem_sh;
    logic                          fits;

    assign rem_sh = {rem_reg, num_reg[ppt_pkg::DIV_N_W-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && (cnt_reg == '0)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            cnt_reg <= ppt_pkg::DIV_C_W'(ppt_pkg::DIV_N_W - 1);
            num_reg <= num;
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            num_reg <= num_reg << 1;
            if (fits) begin
                rem_reg <= ppt_pkg::DIV_D_W'(rem_sh - {1'b0, den_reg});
                q_reg   <= {q_reg[ppt_pkg::DIV_Q_W-2:0], 1'b1};
            end else begin
                rem_reg <= rem_sh[ppt_pkg::DIV_D_W-1:0];
                q_reg   <= {q_reg[ppt_pkg::DIV_Q_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

### verif/tb_position_pnl_tracker.sv
`timescale 1ns / 1ps
module tb_position_pnl_tracker;

    localparam logic [1:0] FUNC_REPORT = 2'd2;
    localparam logic [1:0] FUNC_SPARE  = 2'd3;
    localparam logic [63:0] CNT_CAP = 64'h0000_FFFF_FFFF_FFFF;
    localparam longint CYCLE_LIMIT = 64'd3_000_000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_we = 1'b0;
    logic [23:0] cfg_wdata = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    ppt_pkg::ppt_in_t s_item = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    ppt_pkg::ppt_out_t m_item;

    position_pnl_tracker uut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_item(s_item),
        .m_valid(m_valid), .m_ready(m_ready), .m_item(m_item)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // shadow of the block's accounting state
    longint      pos_sh;
    longint      avg_sh;
    logic [63:0] realised_sh;
    logic [63:0] fees_sh;
    logic [63:0] contracts_sh;
    logic [23:0] mult_sh;

    ppt_pkg::ppt_in_t  pending_items[$];
    ppt_pkg::ppt_out_t expected_results[$];
    int  errors = 0;
    int  results_seen = 0;
    longint cycles = 0;
    bit  hold_sender = 1'b0;
    int  fills_seen = 0, adopts_seen = 0, crossings = 0;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [63:0] magnitude(longint x);
        return x < 0 ? -x : x;
    endfunction

    // count*mult*|diff| formed exactly, shifted by 8, saturated
    function automatic logic [63:0] money_of(bit neg, logic [63:0] cm, logic [63:0] dmag);
        logic [127:0] p;
        logic [127:0] s;
        logic [63:0]  lim;
        logic [63:0]  m;
        p = {64'd0, cm} * {64'd0, dmag};
        s = p >> 8;
        lim = neg ? ppt_pkg::MIN64 : ppt_pkg::MAX64;
        m = (s > {64'd0, lim}) ? lim : s[63:0];
        return neg ? -m : m;
    endfunction

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
        logic [63:0] r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63]) r = a[63] ? ppt_pkg::MIN64 : ppt_pkg::MAX64;
        return r;
    endfunction

    function automatic logic [63:0] sub_sat(logic [63:0] a, logic [63:0] b);
        logic [63:0] r;
        r = a - b;
        if (a[63] != b[63] && r[63] != a[63]) r = a[63] ? ppt_pkg::MIN64 : ppt_pkg::MAX64;
        return r;
    endfunction

    // predict the accounting result of one item and advance the shadow state
    function automatic ppt_pkg::ppt_out_t account_item(ppt_pkg::ppt_in_t it);
        ppt_pkg::ppt_out_t r;
        longint q, total, prc, diff, prev;
        logic [63:0] now_pnl, unreal;
        logic signed [127:0] num;
        logic [127:0] nmag, quo;
        logic [63:0] closing;
        bit neg;
        now_pnl = 0;
        unreal = 0;
        prc = longint'(it.price);
        if (it.func == ppt_pkg::FUNC_FILL) begin
            q = it.sell_side ? -longint'(it.fill_size) : longint'(it.fill_size);
            prev = pos_sh;
            if (prev == 0 || ((prev > 0) == (q > 0))) begin
                total = prev + q;
                if (total == 0) avg_sh = 0;
                else begin
                    num = 128'(signed'(avg_sh)) * 128'(signed'(magnitude(prev)))
                        + 128'(signed'(prc)) * 128'(signed'({44'd0, it.fill_size}));
                    nmag = num < 0 ? -num : num;
                    quo = nmag / {64'd0, magnitude(total)};
                    avg_sh = num < 0 ? -longint'(quo[63:0]) : longint'(quo[63:0]);
                end
                if (total > 64'sd2147483647) total = 64'sd2147483647;
                if (total < -64'sd2147483648) total = -64'sd2147483648;
                pos_sh = total;
            end else begin
                closing = (it.fill_size < magnitude(prev)) ? it.fill_size : magnitude(prev);
                diff = prc - avg_sh;
                neg = (prev < 0) != (diff < 0);
                now_pnl = money_of(neg, closing * mult_sh, magnitude(diff));
                realised_sh = add_sat(realised_sh, now_pnl);
                pos_sh = prev + q;
                if (pos_sh == 0) avg_sh = 0;
                else if ((pos_sh > 0) != (prev > 0)) begin
                    avg_sh = prc;
                    crossings++;
                end
            end
            fees_sh = add_sat(fees_sh, 64'(signed'(it.fill_fee)));
            contracts_sh = contracts_sh + it.fill_size;
            if (contracts_sh > CNT_CAP) contracts_sh = CNT_CAP;
        end else if (it.func == ppt_pkg::FUNC_ADOPT) begin
            pos_sh = longint'(it.adopted_position);
            avg_sh = (pos_sh != 0) ? prc : 0;
        end
        if (it.mark_valid && pos_sh != 0) begin
            diff = longint'(it.mark_price) - avg_sh;
            neg = (pos_sh < 0) != (diff < 0);
            unreal = money_of(neg, magnitude(pos_sh) * mult_sh, magnitude(diff));
        end
        r.realised_this_fill = now_pnl;
        r.net_position = pos_sh[31:0];
        r.average_price = avg_sh[39:0];
        r.realised_total = realised_sh;
        r.fees_total = fees_sh;
        r.unrealised_pnl = unreal;
        r.net_pnl = sub_sat(add_sat(realised_sh, unreal), fees_sh);
        r.contracts_total = contracts_sh[47:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch on result %0d: %s got %h expected %h", results_seen, field, got, want);
        errors++;
    endtask

    // append one item to the driver's queue
    task automatic queue_item(ppt_pkg::ppt_in_t it);
        pending_items.insert(pending_items.size(), it);
    endtask

    // driver: one item at a time from the pending queue, random gaps between items
    int send_gap = 0;
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.insert(expected_results.size(), account_item(s_item));
                if (s_item.func == ppt_pkg::FUNC_FILL) fills_seen++;
                if (s_item.func == ppt_pkg::FUNC_ADOPT) adopts_seen++;
                void'(pending_items.pop_front());
                send_gap = gap_len();
            end
            if (!(s_valid && !s_ready)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (!hold_sender && pending_items.size() > 0) begin
                    s_valid <= 1'b1;
                    s_item <= pending_items[0];
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random backpressure and field-by-field compare
    int recv_gap = 0;
    always @(posedge aclk) begin
        ppt_pkg::ppt_out_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("result %0d arrived with nothing expected", results_seen);
                    errors++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_item.realised_this_fill !== want.realised_this_fill)
                        report_mismatch("realised_this_fill", m_item.realised_this_fill,
                                        want.realised_this_fill);
                    if (m_item.net_position !== want.net_position)
                        report_mismatch("net_position", 64'(m_item.net_position),
                                        64'(want.net_position));
                    if (m_item.average_price !== want.average_price)
                        report_mismatch("average_price", 64'(m_item.average_price),
                                        64'(want.average_price));
                    if (m_item.realised_total !== want.realised_total)
                        report_mismatch("realised_total", m_item.realised_total,
                                        want.realised_total);
                    if (m_item.fees_total !== want.fees_total)
                        report_mismatch("fees_total", m_item.fees_total, want.fees_total);
                    if (m_item.unrealised_pnl !== want.unrealised_pnl)
                        report_mismatch("unrealised_pnl", m_item.unrealised_pnl,
                                        want.unrealised_pnl);
                    if (m_item.net_pnl !== want.net_pnl)
                        report_mismatch("net_pnl", m_item.net_pnl, want.net_pnl);
                    if (m_item.contracts_total !== want.contracts_total)
                        report_mismatch("contracts_total", 64'(m_item.contracts_total),
                                        64'(want.contracts_total));
                end
                recv_gap = gap_len();
            end
            if (recv_gap > 0) begin
                recv_gap--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic [39:0] rand_price();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 40'({$urandom, $urandom});
        if (r == 1) return $urandom_range(0, 1) ? 40'h7F_FFFF_FFFF : 40'h80_0000_0000;
        // typical market price between about 2440 and 2560 in Q.16
        return 40'(longint'($urandom_range(3_900_000, 4_100_000)) * 64'd4096 / 64'd100);
    endfunction

    function automatic ppt_pkg::ppt_in_t rand_item();
        ppt_pkg::ppt_in_t it;
        int r;
        r = $urandom_range(0, 99);
        it.func = r < 70 ? ppt_pkg::FUNC_FILL :
                  (r < 80 ? ppt_pkg::FUNC_ADOPT : (r < 97 ? FUNC_REPORT : FUNC_SPARE));
        it.sell_side = 1'($urandom_range(0, 1));
        r = $urandom_range(0, 19);
        it.fill_size = r == 0 ? 20'hFFFFF :
                       (r == 1 ? 20'($urandom) : 20'($urandom_range(0, 40)));
        it.price = rand_price();
        r = $urandom_range(0, 19);
        it.fill_fee = r == 0 ? $urandom : 32'(signed'($urandom_range(0, 200_000)) - 10_000);
        r = $urandom_range(0, 9);
        it.adopted_position = r == 0 ? $urandom : 32'(signed'($urandom_range(0, 200)) - 100);
        if ($urandom_range(0, 19) == 0) it.adopted_position = 0;
        it.mark_price = rand_price();
        it.mark_valid = $urandom_range(0, 5) != 0;
        return it;
    endfunction

    function automatic ppt_pkg::ppt_in_t make_item(logic [1:0] f, bit sell, logic [19:0] size,
                                                   logic [39:0] prc, logic [31:0] fee,
                                                   logic [31:0] adopt, logic [39:0] mark,
                                                   bit mv);
        ppt_pkg::ppt_in_t it;
        it.func = f; it.sell_side = sell; it.fill_size = size; it.price = prc;
        it.fill_fee = fee; it.adopted_position = adopt; it.mark_price = mark;
        it.mark_valid = mv;
        return it;
    endfunction

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        // let the block return to idle before anything else happens
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_mult(logic [23:0] v);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we <= 1'b0;
        mult_sh = v;
    endtask

    localparam logic [39:0] P4000 = 40'd262_144_000;
    localparam logic [39:0] P4010 = 40'd262_799_360;
    localparam logic [39:0] PMAX  = 40'h7F_FFFF_FFFF;
    localparam logic [39:0] PMIN  = 40'h80_0000_0000;
    localparam logic [23:0] MULT_SET[4] = '{24'd12_800, 24'hFF_FFFF, 24'd0, 24'd1};

    initial begin
        pos_sh = 0; avg_sh = 0; realised_sh = 0; fees_sh = 0; contracts_sh = 0;
        mult_sh = ppt_pkg::MULT_RESET;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: open, add, partial close, exact flat, cross zero, adopt, extremes
        queue_item(make_item(FUNC_REPORT, 0, 0, 0, 0, 0, P4000, 1));
        queue_item(make_item(ppt_pkg::FUNC_FILL, 0, 10, P4000, 32'd65536, 0, P4010, 1));
        queue_item(make_item(ppt_pkg::FUNC_FILL, 0, 5, P4010, 32'd65536, 0, P4010, 1));
        queue_item(make_item(ppt_pkg::FUNC_FILL, 1, 3, P4010, 32'd0, 0, P4000, 1));
        queue_item(make_item(ppt_pkg::FUNC_FILL, 1, 0, P4010, 32'd7, 0, P4000, 0));
        queue_item(make_item(ppt_pkg::FUNC_FILL, 1, 12, P4000, 32'hFFFF_0000, 0, P4010, 1));
        queue_item(make_item(ppt_pkg::FUNC_FILL, 0, 0, P4000, 32'd1, 0, P4000, 1));
        queue_item(make_item(ppt_pkg::FUNC_FILL, 1, 4, P4010, 0, 0, P4000, 1));
        queue_item(make_item(ppt_pkg::FUNC_FILL, 0, 9, P4000, 0, 0, PMAX, 1));
        queue_item(make_item(ppt_pkg::FUNC_ADOPT, 0, 0, PMIN, 0, 32'h7FFF_FFFF, PMAX, 1));
        queue_item(make_item(ppt_pkg::FUNC_FILL, 0, 20'hFFFFF, PMAX, 32'h7FFF_FFFF, 0,
                             PMIN, 1));
        queue_item(make_item(ppt_pkg::FUNC_FILL, 1, 20'hFFFFF, PMIN, 32'h7FFF_FFFF, 0,
                             PMAX, 1));
        queue_item(make_item(ppt_pkg::FUNC_ADOPT, 1, 0, PMAX, 0, 32'h8000_0000, PMIN, 1));
        queue_item(make_item(ppt_pkg::FUNC_FILL, 1, 20'hFFFFF, PMAX, 32'h8000_0000, 0,
                             PMAX, 1));
        queue_item(make_item(ppt_pkg::FUNC_ADOPT, 0, 5, P4000, 0, 32'd0, P4000, 1));
        queue_item(make_item(FUNC_SPARE, 1, 20'hFFFFF, PMAX, 32'hFFFF_FFFF,
                             32'hFFFF_FFFF, PMAX, 1));
        queue_item(make_item(ppt_pkg::FUNC_ADOPT, 0, 0, PMIN, 0, 32'hFFFF_FFFF, PMIN, 0));
        queue_item(make_item(FUNC_REPORT, 0, 0, 0, 0, 0, PMAX, 1));
        wait_drained();

        // random phases across multiplier settings; one phase holds the sender
        for (int ph = 0; ph < 4; ph++) begin
            write_mult(MULT_SET[ph]);
            for (int k = 0; k < 375; k++) begin
                queue_item(rand_item());
                if (k == 180 && ph == 1) begin
                    wait_drained();
                    hold_sender = 1'b1;
                    repeat (5) @(posedge aclk);
                    hold_sender = 1'b0;
                end
            end
            wait_drained();
        end
        write_mult(ppt_pkg::MULT_RESET);
        queue_item(rand_item());
        wait_drained();
        repeat (250) @(posedge aclk);

        $display("covered %0d results: %0d fills, %0d adopts, %0d zero crossings",
                 results_seen, fills_seen, adopts_seen, crossings);
        $display("multiplier settings swept from zero to full scale, %0d mismatches", errors);
        if (errors == 0 && expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
